>>> rtl/mshr_pkg.sv
`timescale 1ns / 1ps
package mshr_pkg;
    localparam int DefEntries    = 16;
    localparam int DefQueueDepth = 4;
    localparam int MaxOut        = 16;

    localparam logic [2:0] OP_ALLOC     = 3'd0;
    localparam logic [2:0] OP_FILL      = 3'd1;
    localparam logic [2:0] OP_PEEK      = 3'd2;
    localparam logic [2:0] OP_POP       = 3'd3;
    localparam logic [2:0] OP_LIST_OUT  = 3'd4;
    localparam logic [2:0] OP_CLEAR_OUT = 3'd5;
    localparam logic [2:0] OP_QUERY     = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    typedef struct packed {
        logic       exec;      // single-result operation, apply and report
        logic       scan_init; // load scan pointer for a listing operation
        logic       scan_step; // examine one entry
    } mshr_cmd_t;

    typedef struct packed {
        logic scan_done;
    } mshr_sts_t;
endpackage

>>> rtl/mshr_ctrl.sv
`timescale 1ns / 1ps
module mshr_ctrl
    import mshr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] operation,
    input  mshr_sts_t  sts,
    output mshr_cmd_t  cmd,
    output logic       busy
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INIT = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_PEEK || operation == OP_LIST_OUT)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                // turnaround state so state updates settle
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

>>> rtl/mshr_datapath.sv
`timescale 1ns / 1ps
module mshr_datapath
    import mshr_pkg::*;
#(
    parameter int ENTRIES     = DefEntries,
    parameter int QUEUE_DEPTH = DefQueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mshr_cmd_t   cmd,
    input  logic [2:0]  operation,
    input  logic [31:0] block_address,
    input  logic [15:0] request_tag,
    input  logic [3:0]  entry_index,
    output mshr_sts_t   sts,
    output logic        strobe,
    output logic [1:0]  status,
    output logic        found,
    output logic [3:0]  result_index,
    output logic [15:0] result_tag,
    output logic        last
);
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(ENTRIES + 1);
    localparam int TW = EW + QW;

    logic [ENTRIES-1:0] valid_reg, ready_reg, outst_reg;
    logic [31:0]        addr_reg [ENTRIES];
    logic [QW-1:0]      head_reg [ENTRIES];
    logic [CW-1:0]      count_reg [ENTRIES];
    logic [EW-1:0]      scan_start_reg;
    logic [15:0]        tags_mem [ENTRIES*QUEUE_DEPTH];

    // listing scan
    logic              peek_reg;
    logic [SW-1:0]     step_reg;
    logic [EW-1:0]     pos_reg;
    logic [4:0]        nfound_reg;
    logic              pend_reg;
    logic [EW-1:0]     pend_idx_reg;
    logic              emit_reg;
    logic [15:0]       pend_tag_reg;
    logic              fin_reg;

    logic [ENTRIES-1:0] match, merge_ok;
    logic               any_merge, any_free, any_match;
    logic [EW-1:0]      merge_idx, free_idx;
    logic               idx_ok;
    logic [EW-1:0]      idx;

    always_comb
    begin
        any_merge = 1'b0;
        any_free  = 1'b0;
        merge_idx = '0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i]    = valid_reg[i] && addr_reg[i] == block_address;
            merge_ok[i] = match[i] && count_reg[i] < CW'(QUEUE_DEPTH);
            if (merge_ok[i])
            begin
                any_merge = 1'b1;
                merge_idx = EW'(i);
            end
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = EW'(i);
            end
        end
        any_match = |match;
    end

    assign idx_ok = ({3'b000, entry_index} < 7'(ENTRIES));
    assign idx    = EW'(entry_index);

    // scan candidate
    logic          cand_hit;
    logic [EW-1:0] next_pos;
    always_comb
    begin
        cand_hit = peek_reg ? (valid_reg[pos_reg] && ready_reg[pos_reg])
                            : (valid_reg[pos_reg] && outst_reg[pos_reg]);
        next_pos = (pos_reg == EW'(ENTRIES - 1)) ? '0 : pos_reg + 1'b1;
    end
    logic scan_end;
    assign scan_end = (step_reg == SW'(ENTRIES - 1))
                   || (nfound_reg == 5'(MaxOut - 1) && cand_hit);
    assign sts.scan_done = cmd.scan_step && scan_end;

    // tail slot of the merge entry, wrapped at the queue depth
    logic [QW:0]   slot_sum;
    logic [TW-1:0] waddr;
    logic          we;
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        slot_sum = {1'b0, head_reg[merge_idx]} + (QW+1)'(count_reg[merge_idx]);
        if (slot_sum >= (QW+1)'(QUEUE_DEPTH))
            slot_sum = slot_sum - (QW+1)'(QUEUE_DEPTH);
        if (cmd.exec && operation == OP_ALLOC && (any_merge || any_free))
        begin
            we = 1'b1;
            if (any_merge)
                waddr = TW'(merge_idx) * TW'(QUEUE_DEPTH) + TW'(slot_sum);
            else
                waddr = TW'(free_idx) * TW'(QUEUE_DEPTH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tags_mem[waddr] <= request_tag;
        end
    end

    // registered read of the head tag at the scan position
    logic [15:0]   rd_tag_reg;
    always_ff @(posedge clk)
    begin
        rd_tag_reg <= tags_mem[TW'(pos_reg) * TW'(QUEUE_DEPTH) + TW'(head_reg[pos_reg])];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && operation == OP_ALLOC && !any_merge && any_free)
            addr_reg[free_idx] <= block_address;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ready_reg <= '0;
            outst_reg <= '0;
            scan_start_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            strobe <= 1'b0;
            status <= ST_OK;
            found <= 1'b0;
            result_index <= '0;
            result_tag <= '0;
            last <= 1'b0;
            peek_reg <= 1'b0;
            step_reg <= '0;
            pos_reg <= '0;
            nfound_reg <= '0;
            pend_reg <= 1'b0;
            pend_idx_reg <= '0;
            pend_tag_reg <= '0;
            emit_reg <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            // the tag of a hit lands in rd_tag_reg in the cycle after the hit
            emit_reg <= cmd.scan_step && cand_hit;
            if (emit_reg)
            begin
                pend_tag_reg <= rd_tag_reg;
            end
            if (cmd.exec)
            begin
                strobe <= 1'b1;
                found <= 1'b0;
                result_index <= '0;
                result_tag <= '0;
                last <= 1'b1;
                status <= ST_NONE;
                case (operation)
                    OP_ALLOC:
                    begin
                        if (any_merge)
                        begin
                            count_reg[merge_idx] <= count_reg[merge_idx] + 1'b1;
                            status <= ST_OK;
                        end
                        else if (any_free)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            outst_reg[free_idx] <= 1'b1;
                            head_reg[free_idx] <= '0;
                            count_reg[free_idx] <= CW'(1);
                            status <= ST_OK;
                        end
                    end
                    OP_FILL:
                    begin
                        ready_reg <= ready_reg | match;
                        status <= any_match ? ST_OK : ST_NONE;
                    end
                    OP_POP:
                    begin
                        if (!idx_ok || !valid_reg[idx] || count_reg[idx] == '0)
                            status <= ST_ERROR;
                        else
                        begin
                            status <= ST_OK;
                            count_reg[idx] <= count_reg[idx] - 1'b1;
                            if (count_reg[idx] == CW'(1))
                            begin
                                valid_reg[idx] <= 1'b0;
                                ready_reg[idx] <= 1'b0;
                                head_reg[idx] <= '0;
                            end
                            else
                                head_reg[idx] <= (head_reg[idx] == QW'(QUEUE_DEPTH - 1))
                                               ? '0 : head_reg[idx] + 1'b1;
                        end
                    end
                    OP_CLEAR_OUT:
                    begin
                        if (!idx_ok || !outst_reg[idx])
                            status <= ST_ERROR;
                        else
                        begin
                            status <= ST_OK;
                            outst_reg[idx] <= 1'b0;
                        end
                    end
                    OP_QUERY:
                    begin
                        status <= any_free ? ST_OK : ST_NONE;
                    end
                    default:
                    begin
                        status <= ST_NONE;
                    end
                endcase
            end
            if (cmd.scan_init)
            begin
                peek_reg <= (operation == OP_PEEK);
                pos_reg <= (operation == OP_PEEK) ? scan_start_reg : '0;
                step_reg <= '0;
                nfound_reg <= '0;
                pend_reg <= 1'b0;
                if (operation == OP_PEEK)
                    scan_start_reg <= (scan_start_reg == EW'(ENTRIES - 1))
                                    ? '0 : scan_start_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                // a hit is held until the next hit or the end of the scan so its last flag is known
                if (cand_hit)
                begin
                    nfound_reg <= nfound_reg + 1'b1;
                    pend_reg <= 1'b1;
                    pend_idx_reg <= pos_reg;
                end
                if (pend_reg && (cand_hit || scan_end))
                begin
                    strobe <= 1'b1;
                    status <= ST_OK;
                    found <= 1'b1;
                    result_index <= 4'(pend_idx_reg);
                    result_tag <= emit_reg ? rd_tag_reg : pend_tag_reg;
                    last <= scan_end && !cand_hit;
                end
                if (scan_end && !pend_reg && !cand_hit)
                begin
                    strobe <= 1'b1;
                    status <= ST_NONE;
                    found <= 1'b0;
                    result_index <= '0;
                    result_tag <= '0;
                    last <= 1'b1;
                end
                pos_reg <= next_pos;
                step_reg <= step_reg + 1'b1;
            end
            if (fin_reg)
            begin
                strobe <= 1'b1;
                status <= ST_OK;
                found <= 1'b1;
                result_index <= 4'(pend_idx_reg);
                result_tag <= emit_reg ? rd_tag_reg : pend_tag_reg;
                last <= 1'b1;
                pend_reg <= 1'b0;
            end
        end
    end

    // final hit is flushed in the cycle after the scan ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_reg <= 1'b0;
        else
            fin_reg <= cmd.scan_step && scan_end && cand_hit;
    end
endmodule

>>> rtl/miss_status_holding_table_core.sv
`timescale 1ns / 1ps
// Miss status holding table. Allocate, fill, pop, clear outstanding and query
// free are single-result operations: the result is on the ports in the cycle
// right after the accepting edge, and busy stays high through the S_INIT
// turnaround state. Peek ready and list outstanding sweep the table one entry
// per cycle, stopping early at MaxOut hits, and emit one result per hit, each
// in the cycle after the next hit or the end of the sweep; the hit found on the
// last step is flushed through fin_reg. Busy stays high through the sweep and
// the flush_reg hold-off. Results appear for one cycle on strobe; the receiver
// cannot stall them. The table is clear after reset.
module miss_status_holding_table_core
    import mshr_pkg::*;
#(
    parameter int ENTRIES     = DefEntries,
    parameter int QUEUE_DEPTH = DefQueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [31:0] block_address,
    input  logic [15:0] request_tag,
    input  logic [3:0]  entry_index,
    output logic        strobe,
    output logic [1:0]  status,
    output logic        found,
    output logic [3:0]  result_index,
    output logic [15:0] result_tag,
    output logic        last
);
    mshr_cmd_t cmd;
    mshr_sts_t sts;
    logic      ctrl_busy;

    mshr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && !busy),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (ctrl_busy)
    );

    mshr_datapath #(
        .ENTRIES     (ENTRIES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (operation),
        .block_address (block_address),
        .request_tag   (request_tag),
        .entry_index   (entry_index),
        .sts           (sts),
        .strobe        (strobe),
        .status        (status),
        .found         (found),
        .result_index  (result_index),
        .result_tag    (result_tag),
        .last          (last)
    );

    // hold off during the final flush cycle of a sweep
    logic flush_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flush_reg <= 1'b0;
        else
            flush_reg <= sts.scan_done;
    end

    assign busy = ctrl_busy || flush_reg;
endmodule

>>> tb/tb_miss_status_holding_table_core.sv
`timescale 1ns / 1ps
module tb_miss_status_holding_table_core;
    import mshr_pkg::*;

    localparam int NENT  = 16;
    localparam int QDEP  = 4;

    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [1:0]  st;
        logic        fnd;
        logic [3:0]  idx;
        logic [15:0] tag;
        logic        lst;
    } mshr_result_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [15:0] tag;
        logic [3:0]  idx;
        bit          has_exp;
        logic [1:0]  exp_st;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  operation;
    logic [31:0] block_address;
    logic [15:0] request_tag;
    logic [3:0]  entry_index;
    logic        strobe;
    logic [1:0]  status;
    logic        found;
    logic [3:0]  result_index;
    logic [15:0] result_tag;
    logic        last;

    miss_status_holding_table_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .block_address(block_address),
        .request_tag(request_tag), .entry_index(entry_index),
        .strobe(strobe), .status(status), .found(found),
        .result_index(result_index), .result_tag(result_tag), .last(last)
    );

    // predicted table state
    bit          tv_valid [NENT];
    bit          tv_ready [NENT];
    bit          tv_outst [NENT];
    logic [31:0] tv_addr  [NENT];
    logic [15:0] tv_tags  [NENT][QDEP];
    int          tv_head  [NENT];
    int          tv_count [NENT];
    int          tv_scan;

    mshr_result_t pending_results[$];
    int           mismatches;
    int           results_seen;
    int           listed_seen;
    logic [1:0]   pred_first_st;

    // directed table: expected status typed in where obvious
    stim_row_t directed[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #100000;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

    function automatic mshr_result_t mk(logic [1:0] st, logic fnd, logic [3:0] idx,
                                        logic [15:0] tag, logic lst);
        mshr_result_t r;
        r.st = st; r.fnd = fnd; r.idx = idx; r.tag = tag; r.lst = lst;
        return r;
    endfunction

    task automatic predict_table(input logic [2:0] op, input logic [31:0] addr,
                                 input logic [15:0] tag, input logic [3:0] idx);
        mshr_result_t lst[$];
        bit done;
        bit hit;
        int e;
        int base;
        done = 0;
        hit = 0;
        base = pending_results.size();
        case (op)
            OP_ALLOC:
            begin
                for (int i = 0; i < NENT && !done; i++)
                    if (tv_valid[i] && tv_addr[i] == addr && tv_count[i] < QDEP)
                    begin
                        tv_tags[i][(tv_head[i] + tv_count[i]) % QDEP] = tag;
                        tv_count[i]++;
                        done = 1;
                    end
                for (int i = 0; i < NENT && !done; i++)
                    if (!tv_valid[i])
                    begin
                        tv_valid[i] = 1; tv_outst[i] = 1; tv_addr[i] = addr;
                        tv_head[i] = 0; tv_tags[i][0] = tag; tv_count[i] = 1;
                        done = 1;
                    end
                pending_results.push_back(mk(done ? ST_OK : ST_NONE,
                                             1'b0, 4'd0, 16'd0, 1'b1));
            end
            OP_FILL:
            begin
                for (int i = 0; i < NENT; i++)
                    if (tv_valid[i] && tv_addr[i] == addr)
                    begin
                        tv_ready[i] = 1;
                        hit = 1;
                    end
                pending_results.push_back(mk(hit ? ST_OK : ST_NONE,
                                             1'b0, 4'd0, 16'd0, 1'b1));
            end
            OP_PEEK, OP_LIST_OUT:
            begin
                for (int i = 0; i < NENT; i++)
                begin
                    e = (op == OP_PEEK) ? (tv_scan + i) % NENT : i;
                    if (tv_valid[e] && (op == OP_PEEK ? tv_ready[e] : tv_outst[e]))
                        lst.push_back(mk(ST_OK, 1'b1, e[3:0], tv_tags[e][tv_head[e]], 1'b0));
                end
                if (op == OP_PEEK)
                    tv_scan = (tv_scan + 1) % NENT;
                if (lst.size() == 0)
                    lst.push_back(mk(ST_NONE, 1'b0, 4'd0, 16'd0, 1'b1));
                else
                    lst[lst.size() - 1].lst = 1'b1;
                foreach (lst[k])
                    pending_results.push_back(lst[k]);
            end
            OP_POP:
            begin
                if (!tv_valid[idx] || tv_count[idx] == 0)
                    pending_results.push_back(mk(ST_ERROR, 1'b0, 4'd0, 16'd0, 1'b1));
                else
                begin
                    tv_head[idx] = (tv_head[idx] + 1) % QDEP;
                    tv_count[idx]--;
                    if (tv_count[idx] == 0)
                    begin
                        tv_valid[idx] = 0; tv_ready[idx] = 0; tv_head[idx] = 0;
                    end
                    pending_results.push_back(mk(ST_OK, 1'b0, 4'd0, 16'd0, 1'b1));
                end
            end
            OP_CLEAR_OUT:
            begin
                if (!tv_outst[idx])
                    pending_results.push_back(mk(ST_ERROR, 1'b0, 4'd0, 16'd0, 1'b1));
                else
                begin
                    tv_outst[idx] = 0;
                    pending_results.push_back(mk(ST_OK, 1'b0, 4'd0, 16'd0, 1'b1));
                end
            end
            OP_QUERY:
            begin
                for (int i = 0; i < NENT; i++)
                    if (!tv_valid[i])
                        hit = 1;
                pending_results.push_back(mk(hit ? ST_OK : ST_NONE,
                                             1'b0, 4'd0, 16'd0, 1'b1));
            end
            default:
                pending_results.push_back(mk(ST_NONE, 1'b0, 4'd0, 16'd0, 1'b1));
        endcase
        pred_first_st = pending_results[base].st;
    endtask

    // compare every strobed result against the oldest prediction
    always @(posedge clk)
    begin
        mshr_result_t got;
        mshr_result_t want;
        if (rst_n && strobe)
        begin
            got = mk(status, found, result_index, result_tag, last);
            results_seen++;
            if (found)
                listed_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result st=%0d fnd=%0d idx=%0d tag=%h last=%0d",
                             status, found, result_index, result_tag, last);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d fnd=%0d idx=%0d tag=%h last=%0d",
                                  " | got st=%0d fnd=%0d idx=%0d tag=%h last=%0d"},
                                 want.st, want.fnd, want.idx, want.tag, want.lst,
                                 got.st, got.fnd, got.idx, got.tag, got.lst);
                end
            end
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [31:0] addr,
                             input logic [15:0] tag, input logic [3:0] idx,
                             input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        operation     <= op;
        block_address <= addr;
        request_tag   <= tag;
        entry_index   <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // item accepted at this edge
        predict_table(op, addr, tag, idx);
    endtask

    function automatic stim_row_t row(logic [2:0] op, logic [31:0] addr, logic [15:0] tag,
                                      logic [3:0] idx, bit he, logic [1:0] es);
        stim_row_t r;
        r.op = op; r.addr = addr; r.tag = tag; r.idx = idx; r.has_exp = he; r.exp_st = es;
        return r;
    endfunction

    logic [31:0] addr_pool[4];

    initial
    begin
        int wait_cycles;
        int pick;
        logic [2:0] op;
        logic [31:0] addr;
        mismatches = 0;
        results_seen = 0;
        listed_seen = 0;
        for (int i = 0; i < NENT; i++)
        begin
            tv_valid[i] = 0; tv_ready[i] = 0; tv_outst[i] = 0;
            tv_addr[i] = 0; tv_head[i] = 0; tv_count[i] = 0;
        end
        tv_scan = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = 3'd0;
        block_address = 32'd0;
        request_tag = 16'd0;
        entry_index = 4'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: empty listings, errors, then extremes
        directed.push_back(row(OP_PEEK,      32'h0, 16'h0, 4'd0,  1'b1, ST_NONE));
        directed.push_back(row(OP_LIST_OUT,  32'h0, 16'h0, 4'd0,  1'b1, ST_NONE));
        directed.push_back(row(OP_POP,       32'h0, 16'h0, 4'd15, 1'b1, ST_ERROR));
        directed.push_back(row(OP_CLEAR_OUT, 32'h0, 16'h0, 4'd0,  1'b1, ST_ERROR));
        directed.push_back(row(OP_FILL,      32'hFFFFFFFF, 16'h0, 4'd0, 1'b1, ST_NONE));
        directed.push_back(row(OP_QUERY,     32'h0, 16'h0, 4'd0,  1'b1, ST_OK));
        directed.push_back(row(OP_UNUSED,    32'hFFFFFFFF, 16'hFFFF, 4'd15, 1'b1, ST_NONE));
        directed.push_back(row(OP_ALLOC,     32'hFFFFFFFF, 16'hFFFF, 4'd0, 1'b1, ST_OK));
        directed.push_back(row(OP_ALLOC,     32'h0, 16'h0000, 4'd0, 1'b1, ST_OK));
        for (int k = 0; k < 4; k++)
            directed.push_back(row(OP_ALLOC, 32'hFFFFFFFF, 16'(16'hA000 + k), 4'd0,
                                   1'b0, ST_OK));
        directed.push_back(row(OP_FILL,      32'hFFFFFFFF, 16'h0, 4'd0, 1'b1, ST_OK));
        directed.push_back(row(OP_PEEK,      32'h0, 16'h0, 4'd0,  1'b0, ST_OK));
        directed.push_back(row(OP_LIST_OUT,  32'h0, 16'h0, 4'd0,  1'b0, ST_OK));
        directed.push_back(row(OP_CLEAR_OUT, 32'h0, 16'h0, 4'd1,  1'b1, ST_OK));
        directed.push_back(row(OP_CLEAR_OUT, 32'h0, 16'h0, 4'd1,  1'b1, ST_ERROR));
        directed.push_back(row(OP_POP,       32'h0, 16'h0, 4'd1,  1'b1, ST_OK));
        directed.push_back(row(OP_POP,       32'h0, 16'h0, 4'd0,  1'b0, ST_OK));
        directed.push_back(row(OP_POP,       32'h0, 16'h0, 4'd1,  1'b1, ST_ERROR));
        directed.push_back(row(OP_PEEK,      32'h0, 16'h0, 4'd0,  1'b0, ST_OK));

        foreach (directed[k])
        begin
            send_item(directed[k].op, directed[k].addr, directed[k].tag,
                      directed[k].idx, 1'b1);
            if (directed[k].has_exp && pred_first_st !== directed[k].exp_st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: table expects status %0d, predictor %0d",
                             k, directed[k].exp_st, pred_first_st);
            end
        end

        // random part: a few hot addresses so merges, fills and a full table happen
        for (int n = 0; n < 90; n++)
        begin
            if (n % 40 == 0)
                for (int a = 0; a < 4; a++)
                    addr_pool[a] = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = OP_ALLOC;
            else if (pick < 47) op = OP_FILL;
            else if (pick < 57) op = OP_PEEK;
            else if (pick < 75) op = OP_POP;
            else if (pick < 83) op = OP_LIST_OUT;
            else if (pick < 91) op = OP_CLEAR_OUT;
            else if (pick < 97) op = OP_QUERY;
            else                op = OP_UNUSED;
            addr = ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[$urandom_range(0, 3)];
            send_item(op, addr, 16'($urandom), 4'($urandom), n < 70);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);

        $display("covered %0d results, %0d listed entries, over all seven operations",
                 results_seen, listed_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
